>>> rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Types, constants and arithmetic helpers shared by the link transform blocks.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int ANG_W    = 33;  // theta plus joint value, exact
  localparam int RED_W    = 34;  // biased angle for the modulo pipeline
  localparam int REM_W    = 19;  // remainder below 2*pi
  localparam int FOLD_W   = 21;  // signed folded angle
  localparam int CX_W     = 34;  // CORDIC x and y, Q2.30 with headroom
  localparam int CZ_W     = 33;  // CORDIC residual angle, Q2.30
  localparam int TRIG_W   = 18;  // sine and cosine in Q2.16
  localparam int PROD_W   = 50;  // 32 x 18 product
  localparam int SPROD_W  = 36;  // 18 x 18 product
  localparam int RED_STEPS = 15; // quotient bits of the modulo

  localparam logic [RED_W-1:0] TWO_PI_U    = 34'd411775;
  // smallest multiple of 2*pi that lifts every 33-bit angle above zero
  localparam logic [RED_W-1:0] REDUCE_BIAS = 34'd4295225025;
  localparam logic signed [FOLD_W-1:0] TWO_PI_S  = 21'sd411775;
  localparam logic signed [FOLD_W-1:0] PI_S      = 21'sd205887;
  localparam logic signed [FOLD_W-1:0] HALF_PI_S = 21'sd102944;
  localparam logic signed [CX_W-1:0]   CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CX_W-1:0]   ROUND_Q14   = 34'sd8192;

  typedef enum logic [2:0] {
    REG_CONVENTION  = 3'd0,
    REG_JOINT_KIND  = 3'd1,
    REG_LINK_OFFSET = 3'd2,
    REG_JOINT_ANGLE = 3'd3,
    REG_LINK_LENGTH = 3'd4,
    REG_LINK_TWIST  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CONV_CLASSIC = 1'b0,
    CONV_CRAIG   = 1'b1
  } conv_t;

  typedef enum logic {
    JOINT_PRISMATIC = 1'b0,
    JOINT_REVOLUTE  = 1'b1
  } joint_t;

  // one classified item as it waits in the queue
  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic signed [31:0]      offset;
  } item_t;

  // link settings the back end reads
  typedef struct packed {
    conv_t              convention;
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
  } link_cfg_t;

  typedef struct packed {
    logic signed [CZ_W-1:0] z;
    logic                   flip;
  } fold_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    begin
      case (i)
        0:  v = 30'h3243F6A8;
        1:  v = 30'h1DAC6705;
        2:  v = 30'h0FADBAFC;
        3:  v = 30'h07F56EA6;
        4:  v = 30'h03FEAB76;
        5:  v = 30'h01FFD55B;
        6:  v = 30'h00FFFAAA;
        7:  v = 30'h007FFF55;
        8:  v = 30'h003FFFEA;
        9:  v = 30'h001FFFFD;
        10: v = 30'h000FFFFF;
        11: v = 30'h0007FFFF;
        12: v = 30'h0003FFFF;
        13: v = 30'h0001FFFF;
        14: v = 30'h0000FFFF;
        15: v = 30'h00007FFF;
        16: v = 30'h00003FFF;
        17: v = 30'h00001FFF;
        18: v = 30'h00000FFF;
        19: v = 30'h000007FF;
        20: v = 30'h000003FF;
        21: v = 30'h000001FF;
        22: v = 30'h000000FF;
        23: v = 30'h0000007F;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
        return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[31:0];
    end
  endfunction

  // one compare-and-subtract of the modulo by 2*pi shifted left
  function automatic logic [RED_W-1:0] red_step(input logic [RED_W-1:0] v, input int sh);
    logic [RED_W-1:0] c;
    begin
      c = TWO_PI_U << sh;
      return (v >= c) ? (v - c) : v;
    end
  endfunction

  // remainder in [0, 2*pi) -> [-pi/2, pi/2] plus a half-turn flag, scaled to Q2.30
  function automatic fold_t fold_angle(input logic [REM_W-1:0] r);
    logic signed [FOLD_W-1:0] a;
    fold_t f;
    begin
      a = $signed({2'b00, r});
      if (a > PI_S) begin
        a = a - TWO_PI_S;
      end
      f.flip = 1'b0;
      if (a > HALF_PI_S) begin
        a = a - PI_S;
        f.flip = 1'b1;
      end else if (a < -HALF_PI_S) begin
        a = a + PI_S;
        f.flip = 1'b1;
      end
      f.z = {a[18:0], 14'b0};
      return f;
    end
  endfunction

  // optional negation, round half up from Q18.32 to Q16.16, saturate
  function automatic logic signed [31:0] mulq_fin(input logic signed [PROD_W-1:0] p,
                                                  input logic neg);
    logic signed [PROD_W:0] t;
    logic signed [PROD_W-16:0] q;
    begin
      t = neg ? -{p[PROD_W-1], p} : {p[PROD_W-1], p};
      t = t + 51'sd32768;
      q = t[PROD_W:16];
      if (q > 35'sh0_7FFF_FFFF) begin
        return 32'sh7FFF_FFFF;
      end
      if (q < -35'sh0_8000_0000) begin
        return 32'sh8000_0000;
      end
      return q[31:0];
    end
  endfunction

endpackage

>>> rtl/dht_front.sv
// ----------------------------------------------------------------------------
// dht_front
// Link register file and input stage: forms the effective angle and offset.
// ----------------------------------------------------------------------------
module dht_front import dht_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] joint_input,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item,
  output link_cfg_t          link_cfg
);

  conv_t              convention;
  joint_t             joint_kind;
  logic signed [31:0] link_offset;
  logic signed [31:0] joint_angle;
  logic signed [31:0] link_length;
  logic signed [31:0] link_twist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      convention  <= CONV_CLASSIC;
      joint_kind  <= JOINT_REVOLUTE;
      link_offset <= '0;
      joint_angle <= '0;
      link_length <= '0;
      link_twist  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONVENTION:  convention  <= conv_t'(cfg_data[0]);
        REG_JOINT_KIND:  joint_kind  <= joint_t'(cfg_data[0]);
        REG_LINK_OFFSET: link_offset <= cfg_data;
        REG_JOINT_ANGLE: joint_angle <= cfg_data;
        REG_LINK_LENGTH: link_length <= cfg_data;
        REG_LINK_TWIST:  link_twist  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (joint_kind == JOINT_REVOLUTE) begin
      push_item.angle  = {joint_angle[31], joint_angle} + {joint_input[31], joint_input};
      push_item.offset = link_offset;
    end else begin
      push_item.angle  = {joint_angle[31], joint_angle};
      push_item.offset = sat_add32(link_offset, joint_input);
    end
  end

  assign link_cfg.convention  = convention;
  assign link_cfg.link_length = link_length;
  assign link_cfg.link_twist  = link_twist;

endmodule

>>> rtl/dht_fifo.sv
// ----------------------------------------------------------------------------
// dht_fifo
// Short queue between the input stage and the transform pipeline.
// ----------------------------------------------------------------------------
module dht_fifo import dht_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t pop_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [0:DEPTH-1];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

>>> rtl/dht_cordic.sv
// ----------------------------------------------------------------------------
// dht_cordic
// Pipelined rotation-mode CORDIC, one iteration per stage, rounded to Q2.16.
// ----------------------------------------------------------------------------
module dht_cordic import dht_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CZ_W-1:0]   z_in,
  input  logic                     flip_in,
  output logic signed [TRIG_W-1:0] cos_out,
  output logic signed [TRIG_W-1:0] sin_out
);

  logic signed [CX_W-1:0] xr [0:STEPS-1];
  logic signed [CX_W-1:0] yr [0:STEPS-1];
  logic signed [CZ_W-1:0] zr [0:STEPS-1];
  logic                   fr [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [CX_W-1:0] xi;
    logic signed [CX_W-1:0] yi;
    logic signed [CZ_W-1:0] zi;
    logic                   fi;
    logic signed [CZ_W-1:0] at;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
    end else begin : g_rest
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign fi = fr[i-1];
    end

    assign at = $signed({3'b000, atan_q30(i)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CZ_W-1]) begin
          xr[i] <= xi - (yi >>> i);
          yr[i] <= yi + (xi >>> i);
          zr[i] <= zi - at;
        end else begin
          xr[i] <= xi + (yi >>> i);
          yr[i] <= yi - (xi >>> i);
          zr[i] <= zi + at;
        end
        fr[i] <= fi;
      end
    end
  end

  logic signed [CX_W-1:0] xq;
  logic signed [CX_W-1:0] yq;

  assign xq = (xr[STEPS-1] + ROUND_Q14) >>> 14;
  assign yq = (yr[STEPS-1] + ROUND_Q14) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= fr[STEPS-1] ? -xq[TRIG_W-1:0] : xq[TRIG_W-1:0];
      sin_out <= fr[STEPS-1] ? -yq[TRIG_W-1:0] : yq[TRIG_W-1:0];
    end
  end

endmodule

>>> rtl/dht_back.sv
// ----------------------------------------------------------------------------
// dht_back
// Transform pipeline: angle reduction, two CORDICs, products, entry layout.
// ----------------------------------------------------------------------------
module dht_back import dht_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               pop,
  input  item_t              q_item,
  input  link_cfg_t          link_cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] r00,
  output logic signed [31:0] r01,
  output logic signed [31:0] r02,
  output logic signed [31:0] r03,
  output logic signed [31:0] r10,
  output logic signed [31:0] r11,
  output logic signed [31:0] r12,
  output logic signed [31:0] r13,
  output logic signed [31:0] r20,
  output logic signed [31:0] r21,
  output logic signed [31:0] r22,
  output logic signed [31:0] r23
);

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && q_valid;

  // modulo 2*pi, one quotient bit per stage
  logic               vr [0:RED_STEPS];
  logic [RED_W-1:0]   ut [0:RED_STEPS];
  logic [RED_W-1:0]   ua [0:RED_STEPS];
  logic signed [31:0] dr [0:RED_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ut[0] <= {q_item.angle[ANG_W-1], q_item.angle} + REDUCE_BIAS;
      ua[0] <= {{2{link_cfg.link_twist[31]}}, link_cfg.link_twist} + REDUCE_BIAS;
      dr[0] <= q_item.offset;
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ut[k+1] <= red_step(ut[k], RED_STEPS - 1 - k);
        ua[k+1] <= red_step(ua[k], RED_STEPS - 1 - k);
        dr[k+1] <= dr[k];
      end
    end
  end

  // fold into the CORDIC range
  logic               vf;
  fold_t              ft;
  fold_t              fa;
  logic signed [31:0] df;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vr[RED_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ft <= fold_angle(ut[RED_STEPS][REM_W-1:0]);
      fa <= fold_angle(ua[RED_STEPS][REM_W-1:0]);
      df <= dr[RED_STEPS];
    end
  end

  logic signed [TRIG_W-1:0] ct_c;
  logic signed [TRIG_W-1:0] st_c;
  logic signed [TRIG_W-1:0] ca_c;
  logic signed [TRIG_W-1:0] sa_c;

  dht_cordic #(.STEPS(STEPS)) u_cordic_theta (
    .clk     (clk),
    .en      (en),
    .z_in    (ft.z),
    .flip_in (ft.flip),
    .cos_out (ct_c),
    .sin_out (st_c)
  );

  dht_cordic #(.STEPS(STEPS)) u_cordic_alpha (
    .clk     (clk),
    .en      (en),
    .z_in    (fa.z),
    .flip_in (fa.flip),
    .cos_out (ca_c),
    .sin_out (sa_c)
  );

  // valid and offset ride alongside the CORDIC stages
  logic               vc [0:STEPS];
  logic signed [31:0] dc [0:STEPS];

  for (genvar s = 0; s <= STEPS; s++) begin : g_dly
    logic               vin;
    logic signed [31:0] din;
    if (s == 0) begin : g_head
      assign vin = vf;
      assign din = df;
    end else begin : g_tail
      assign vin = vc[s-1];
      assign din = dc[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vc[s] <= 1'b0;
      end else if (en) begin
        vc[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dc[s] <= din;
      end
    end
  end

  // products
  logic                      vm;
  logic signed [TRIG_W-1:0]  ct, st, ca, sa;
  logic signed [31:0]        dm;
  logic signed [SPROD_W-1:0] p_stca, p_stsa, p_ctca, p_ctsa;
  logic signed [PROD_W-1:0]  p_act, p_ast, p_dsa, p_dca;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vc[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct     <= ct_c;
      st     <= st_c;
      ca     <= ca_c;
      sa     <= sa_c;
      dm     <= dc[STEPS];
      p_stca <= st_c * ca_c;
      p_stsa <= st_c * sa_c;
      p_ctca <= ct_c * ca_c;
      p_ctsa <= ct_c * sa_c;
      p_act  <= link_cfg.link_length * ct_c;
      p_ast  <= link_cfg.link_length * st_c;
      p_dsa  <= dc[STEPS] * sa_c;
      p_dca  <= dc[STEPS] * ca_c;
    end
  end

  // entry layout and output register
  logic signed [31:0] m [0:11];
  logic signed [31:0] ct32, st32, ca32, sa32;

  assign ct32 = 32'(ct);
  assign st32 = 32'(st);
  assign ca32 = 32'(ca);
  assign sa32 = 32'(sa);

  always_comb begin
    m[0] = ct32;
    if (link_cfg.convention == CONV_CLASSIC) begin
      m[1]  = mulq_fin(PROD_W'(p_stca), 1'b1);
      m[2]  = mulq_fin(PROD_W'(p_stsa), 1'b0);
      m[3]  = mulq_fin(p_act, 1'b0);
      m[4]  = st32;
      m[5]  = mulq_fin(PROD_W'(p_ctca), 1'b0);
      m[6]  = mulq_fin(PROD_W'(p_ctsa), 1'b1);
      m[7]  = mulq_fin(p_ast, 1'b0);
      m[8]  = '0;
      m[9]  = sa32;
      m[10] = ca32;
      m[11] = dm;
    end else begin
      m[1]  = -st32;
      m[2]  = '0;
      m[3]  = link_cfg.link_length;
      m[4]  = mulq_fin(PROD_W'(p_stca), 1'b0);
      m[5]  = mulq_fin(PROD_W'(p_ctca), 1'b0);
      m[6]  = -sa32;
      m[7]  = mulq_fin(p_dsa, 1'b1);
      m[8]  = mulq_fin(PROD_W'(p_stsa), 1'b0);
      m[9]  = mulq_fin(PROD_W'(p_ctsa), 1'b0);
      m[10] = ca32;
      m[11] = mulq_fin(p_dca, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r00 <= m[0];
      r01 <= m[1];
      r02 <= m[2];
      r03 <= m[3];
      r10 <= m[4];
      r11 <= m[5];
      r12 <= m[6];
      r13 <= m[7];
      r20 <= m[8];
      r21 <= m[9];
      r22 <= m[10];
      r23 <= m[11];
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vr[RED_STEPS] |-> ut[RED_STEPS] < TWO_PI_U)
    else $error("angle remainder not below two pi");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vf |-> (ft.z <= 33'sd1686634496 && ft.z >= -33'sd1686634496))
    else $error("folded angle outside quarter turn");

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    vc[STEPS] |-> (ct_c <= 18'sd65600 && ct_c >= -18'sd65600 &&
                   sa_c <= 18'sd65600 && sa_c >= -18'sd65600))
    else $error("CORDIC result beyond unit range");

endmodule

>>> rtl/dh_link_transform.sv
// ----------------------------------------------------------------------------
// dh_link_transform
// Denavit-Hartenberg link transform, upper three rows, signed Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  cfg      | cfg_valid / cfg_ready     | cfg_index[2:0], cfg_data[31:0]
//  in       | in_valid / in_stall       | joint_input
//  out      | out_valid / out_stall     | r00 r01 r02 r03 r10 .. r13 r20 .. r23
//
//  One transaction per cycle in each direction while out_stall is low; from
//  input accept to result an item passes the 15-stage modulo-2*pi pipeline,
//  the fold register, the CORDIC_STEPS-stage CORDIC, the products and the output.
//  The whole back-end pipeline advances whenever the output register is empty
//  or being taken; out_stall freezes it and the queue then fills, raising
//  in_stall after QUEUE_DEPTH more transactions.
//  Synchronous reset loads the link registers (joint_kind revolute, the rest
//  zero) and clears all valid flags; cfg_ready is always high.
//
module dh_link_transform import dht_pkg::*; #(
  parameter int CORDIC_STEPS = 16, // 8..24 iterations
  parameter int QUEUE_DEPTH  = 4   // power of two, at least 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] joint_input,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] r00,
  output logic signed [31:0] r01,
  output logic signed [31:0] r02,
  output logic signed [31:0] r03,
  output logic signed [31:0] r10,
  output logic signed [31:0] r11,
  output logic signed [31:0] r12,
  output logic signed [31:0] r13,
  output logic signed [31:0] r20,
  output logic signed [31:0] r21,
  output logic signed [31:0] r22,
  output logic signed [31:0] r23
);

  // front -> queue
  logic      q_full;
  logic      push;
  item_t     push_item;
  link_cfg_t link_cfg;

  // queue -> back
  logic      q_valid;
  logic      pop;
  item_t     q_item;

  // front end: link registers, effective angle (theta + value, 33 bits exact)
  // or saturated effective offset depending on joint kind
  dht_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .joint_input (joint_input),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item),
    .link_cfg    (link_cfg)
  );

  // decouples the input handshake from the pipeline stall
  dht_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_valid),
    .pop_item  (q_item)
  );

  // back end: reduce theta and alpha, sin/cos by CORDIC, eight products,
  // then the classic or Craig entry layout into the output register
  dht_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_item    (q_item),
    .link_cfg  (link_cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .r00       (r00),
    .r01       (r01),
    .r02       (r02),
    .r03       (r03),
    .r10       (r10),
    .r11       (r11),
    .r12       (r12),
    .r13       (r13),
    .r20       (r20),
    .r21       (r21),
    .r22       (r22),
    .r23       (r23)
  );

endmodule
